/* rtl/core/gnms_pkg.sv */
// Shared types and constants for the greedy non-maximum suppression block.
// Used by gnms_front, gnms_back, the top level and the testbench; depends on nothing.
package gnms_pkg;

  localparam int MaxBoxes   = 64;
  localparam int IdxW       = 6;
  localparam int CntW       = 7;
  localparam int CoordW     = 16;
  localparam int ScoreW     = 16;
  localparam int EdgeW      = CoordW + 2;
  localparam int SideW      = EdgeW + 1;
  localparam int AreaW      = 2 * SideW;
  localparam int BoxW       = 4 * CoordW;
  localparam int OrdW       = IdxW + ScoreW;

  // Configuration register indexes.
  localparam logic [2:0] RegCoordFormat = 3'd0;
  localparam logic [2:0] RegMaxPerClass = 3'd1;
  localparam logic [2:0] RegIouThresh   = 3'd2;
  localparam logic [2:0] RegScoreFilter = 3'd3;
  localparam logic [2:0] RegScoreThresh = 3'd4;

  // One set handed from the front part to the back part.
  typedef struct packed {
    logic [7:0]      batch;
    logic [7:0]      klass;
    logic [CntW-1:0] count;
  } set_job_t;

  // Doubled-unit edges of one box: xl, xh, yl, yh.
  typedef struct packed {
    logic signed [EdgeW-1:0] xl;
    logic signed [EdgeW-1:0] xh;
    logic signed [EdgeW-1:0] yl;
    logic signed [EdgeW-1:0] yh;
  } edges_t;

  function automatic edges_t box_edges(input logic [BoxW-1:0] b, input logic fmt);
    logic signed [EdgeW-1:0] a, bb, c, d;
    edges_t e;
    a  = EdgeW'(signed'(b[4*CoordW-1:3*CoordW]));
    bb = EdgeW'(signed'(b[3*CoordW-1:2*CoordW]));
    c  = EdgeW'(signed'(b[2*CoordW-1:CoordW]));
    d  = EdgeW'(signed'(b[CoordW-1:0]));
    if (!fmt) begin
      e.xl = EdgeW'(2 * ((bb < d) ? bb : d));
      e.xh = EdgeW'(2 * ((bb < d) ? d : bb));
      e.yl = EdgeW'(2 * ((a < c) ? a : c));
      e.yh = EdgeW'(2 * ((a < c) ? c : a));
    end else begin
      e.xl = EdgeW'(2 * a - c);
      e.xh = EdgeW'(2 * a + c);
      e.yl = EdgeW'(2 * bb - d);
      e.yh = EdgeW'(2 * bb + d);
    end
    return e;
  endfunction

endpackage

/* rtl/core/gnms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gnms_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/gnms_front.sv */
// Front part: accepts boxes, counts them per set, and queues a set job.
// Depends on gnms_pkg.
module gnms_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_final,
  input  logic [7:0]              in_batch,
  input  logic [7:0]              in_class,
  input  logic                    back_busy,
  output logic                    in_stall,
  output logic                    store_we,
  output logic [gnms_pkg::IdxW-1:0] store_addr,
  output logic                    job_valid,
  output gnms_pkg::set_job_t      job,
  input  logic                    job_take
);
  import gnms_pkg::*;

  logic [CntW-1:0]  box_count;
  logic             job_full;
  logic             accept;

  // The store is shared with the back part, so boxes wait while a set runs.
  assign in_stall   = job_full || back_busy;
  assign accept     = in_valid && !in_stall;
  assign store_we   = accept && (box_count < CntW'(MaxBoxes));
  assign store_addr = box_count[IdxW-1:0];
  assign job_valid  = job_full;

  // Count boxes and hand over the job on the final transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
      job_full  <= 1'b0;
    end else begin
      if (job_take) begin
        job_full <= 1'b0;
      end
      if (accept) begin
        if (in_final) begin
          job_full  <= 1'b1;
          box_count <= '0;
        end else if (store_we) begin
          box_count <= box_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_final) begin
      job.batch <= in_batch;
      job.klass <= in_class;
      job.count <= store_we ? box_count + 1'b1 : box_count;
    end
  end
endmodule

/* rtl/core/gnms_back.sv */
// Back part: sorts candidates, runs the greedy IoU test, emits results.
// Depends on gnms_pkg and gnms_ram.
module gnms_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_fmt,
  input  logic [6:0]                cfg_max,
  input  logic [15:0]               cfg_iou,
  input  logic                      cfg_filt,
  input  logic [15:0]               cfg_sthr,
  input  logic                      job_valid,
  input  gnms_pkg::set_job_t        job,
  output logic                      job_take,
  output logic                      busy,
  input  logic                      st_we,
  input  logic [gnms_pkg::IdxW-1:0] st_waddr,
  input  logic [gnms_pkg::BoxW-1:0] st_box,
  input  logic [15:0]               st_score,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                batch_out,
  output logic [7:0]                class_out,
  output logic [5:0]                chosen_box,
  output logic                      none_chosen,
  output logic                      final_result
);
  import gnms_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SCAN  = 14'b00000000000010,
    S_SCANW = 14'b00000000000100,
    S_INS   = 14'b00000000001000,
    S_INSW  = 14'b00000000010000,
    S_CAND  = 14'b00000000100000,
    S_CANDW = 14'b00000001000000,
    S_CANDE = 14'b00000010000000,
    S_KEEP  = 14'b00000100000000,
    S_KEEPW = 14'b00001000000000,
    S_KEEPB = 14'b00010000000000,
    S_TEST  = 14'b00100000000000,
    S_EMITR = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } st_t;

  st_t state;
  set_job_t cur;
  logic [CntW-1:0] i, n, pos, kept, k, limit;
  logic [15:0] s_cur;
  logic [IdxW-1:0] cand_idx;
  edges_t cand_e;
  logic [IdxW-1:0] box_raddr, sc_raddr;
  logic [BoxW-1:0] box_rd;
  logic [15:0]     sc_rd;
  logic [IdxW-1:0] ord_raddr, ord_waddr;
  logic [OrdW-1:0] ord_rd, ord_wdata;
  logic            ord_we, ord_shift;
  logic            kept_we;
  logic [IdxW-1:0] kept_raddr, kept_rd;
  logic            suppressed;
  // Test terms and pipeline registers.
  logic signed [SideW-1:0] iw, ih, pw, ph, qw, qh;
  logic                    ovl;
  logic [AreaW-1:0]        inter, a1, a2;
  logic [AreaW+1:0]        uni;
  logic [AreaW+17:0]       lhs, rhs;
  logic [2:0]              tph;

  // Box and score stores, written by the front part.
  gnms_ram #(.Width(BoxW), .Depth(MaxBoxes)) u_box (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_box),
    .raddr(box_raddr), .rdata(box_rd));
  gnms_ram #(.Width(16), .Depth(MaxBoxes)) u_score (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_score),
    .raddr(sc_raddr), .rdata(sc_rd));

  // Candidate order list; each entry holds the box index above its score.
  gnms_ram #(.Width(OrdW), .Depth(MaxBoxes)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rd));

  // Accepted box indices in order of acceptance.
  gnms_ram #(.Width(IdxW), .Depth(MaxBoxes)) u_kept (
    .clk(clk), .we(kept_we), .waddr(kept[IdxW-1:0]), .wdata(cand_idx),
    .raddr(kept_raddr), .rdata(kept_rd));

  assign sc_raddr  = i[IdxW-1:0];
  assign box_raddr = (state == S_CANDW) ? ord_rd[OrdW-1:ScoreW] : kept_rd;
  assign busy      = (state != S_IDLE) || job_valid;
  assign job_take  = (state == S_IDLE) && job_valid;
  assign out_valid = (state == S_EMIT);
  assign limit     = (cfg_max > 7'd64) ? 7'd64 : cfg_max;

  // Insertion step: read the entry above pos, then shift it down or place the new one.
  assign ord_raddr = (state == S_INS) ? pos[IdxW-1:0] - 1'b1 : i[IdxW-1:0];
  assign ord_shift = (state == S_INSW) && (ord_rd[ScoreW-1:0] < s_cur);
  assign ord_we    = ((state == S_INS) && (pos == '0)) || (state == S_INSW);
  assign ord_waddr = pos[IdxW-1:0];
  assign ord_wdata = ord_shift ? ord_rd : {i[IdxW-1:0], s_cur};

  // Kept list: append on acceptance, read ahead by one on each result transfer.
  assign kept_we    = (state == S_KEEP) && (k >= kept);
  assign kept_raddr = k[IdxW-1:0] + IdxW'((state == S_EMIT) && !out_stall);

  // Overlap and area terms of candidate against one kept box.
  always_comb begin
    edges_t q;
    logic signed [EdgeW-1:0] xl, xh, yl, yh;
    q  = box_edges(box_rd, cfg_fmt);
    xl = (cand_e.xl > q.xl) ? cand_e.xl : q.xl;
    xh = (cand_e.xh < q.xh) ? cand_e.xh : q.xh;
    yl = (cand_e.yl > q.yl) ? cand_e.yl : q.yl;
    yh = (cand_e.yh < q.yh) ? cand_e.yh : q.yh;
    ovl = (xh > xl) && (yh > yl);
    iw = SideW'(xh) - SideW'(xl);
    ih = SideW'(yh) - SideW'(yl);
    pw = SideW'(cand_e.xh) - SideW'(cand_e.xl);
    ph = SideW'(cand_e.yh) - SideW'(cand_e.yl);
    qw = SideW'(q.xh) - SideW'(q.xl);
    qh = SideW'(q.yh) - SideW'(q.yl);
  end

  logic ovl_r;
  logic [SideW-1:0] iw_r, ih_r, pw_r, ph_r, qw_r, qh_r;

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i <= '0; n <= '0; pos <= '0; kept <= '0; k <= '0; tph <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job; i <= '0; n <= '0; kept <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (i >= cur.count) begin
            i <= '0; state <= S_CAND;
          end else begin
            state <= S_SCANW;
          end
        end
        S_SCANW: begin
          if (cfg_filt && sc_rd <= cfg_sthr) begin
            i <= i + 1'b1; state <= S_SCAN;
          end else begin
            s_cur <= sc_rd; pos <= n; state <= S_INS;
          end
        end
        S_INS: begin
          // At the head the new entry is written at once; otherwise look above.
          if (pos == '0) begin
            n <= n + 1'b1; i <= i + 1'b1;
            state <= S_SCAN;
          end else begin
            state <= S_INSW;
          end
        end
        S_INSW: begin
          // A lower score above moves down one place; equal scores stay ahead.
          if (ord_shift) begin
            pos <= pos - 1'b1; state <= S_INS;
          end else begin
            n <= n + 1'b1; i <= i + 1'b1;
            state <= S_SCAN;
          end
        end
        S_CAND: begin
          if (i >= n || kept >= limit) begin
            k <= '0; state <= S_EMITR;
          end else begin
            state <= S_CANDW;
          end
        end
        S_CANDW: begin
          cand_idx <= ord_rd[OrdW-1:ScoreW]; state <= S_CANDE;
        end
        S_CANDE: begin
          cand_e <= box_edges(box_rd, cfg_fmt); k <= '0; state <= S_KEEP;
        end
        S_KEEP: begin
          if (k >= kept) begin
            kept <= kept + 1'b1; i <= i + 1'b1; state <= S_CAND;
          end else begin
            state <= S_KEEPW;
          end
        end
        S_KEEPW: begin
          state <= S_KEEPB;
        end
        S_KEEPB: begin
          ovl_r <= ovl;
          iw_r <= iw; ih_r <= ih; pw_r <= pw; ph_r <= ph; qw_r <= qw; qh_r <= qh;
          tph <= '0; state <= S_TEST;
        end
        S_TEST: begin
          tph <= tph + 1'b1;
          if (tph == 3'd3) begin
            if (suppressed) begin
              i <= i + 1'b1; state <= S_CAND;
            end else begin
              k <= k + 1'b1; state <= S_KEEP;
            end
          end
        end
        S_EMITR: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (final_result) begin
              state <= S_IDLE;
            end
            k <= k + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // IoU arithmetic, one multiply rank per cycle.
  always_ff @(posedge clk) begin
    inter <= AreaW'(iw_r) * AreaW'(ih_r);
    a1    <= AreaW'(pw_r) * AreaW'(ph_r);
    a2    <= AreaW'(qw_r) * AreaW'(qh_r);
    uni   <= (AreaW+2)'(a1) + (AreaW+2)'(a2) - (AreaW+2)'(inter);
    lhs   <= (AreaW+18)'({inter, 16'h0000});
    rhs   <= (AreaW+18)'(uni) * (AreaW+18)'(cfg_iou);
  end
  assign suppressed = ovl_r && (lhs > rhs);

  assign batch_out    = cur.batch;
  assign class_out    = cur.klass;
  assign none_chosen  = (kept == '0);
  assign chosen_box   = none_chosen ? '0 : kept_rd;
  assign final_result = none_chosen || (k + 1'b1 == kept);
endmodule

/* rtl/core/greedy_non_max_suppression.sv */
// Top level of the greedy non-maximum suppression block.
// Depends on gnms_pkg, gnms_front, gnms_back and gnms_ram.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | batch_tag class_tag coord_a..d box_score final_box
//  out     | out_valid | out_stall | batch_out class_out chosen_box none_chosen final_result
//
// Up to 64 boxes per set are stored; the final box hands the set to the back part, which
// filters each stored score and inserts each passing box into the candidate order, moving
// lower scores down a place per step. Each candidate is IoU-tested against each kept box
// and kept if none suppresses it. After a read state, one result leaves per cycle unless
// stalled. Input stalls from the final box until the last result transfer, as both parts
// share the box store. Synchronous reset clears control state and configuration.
module greedy_non_max_suppression (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  batch_tag,
  input  logic [7:0]  class_tag,
  input  logic signed [15:0] coord_a,
  input  logic signed [15:0] coord_b,
  input  logic signed [15:0] coord_c,
  input  logic signed [15:0] coord_d,
  input  logic [15:0] box_score,
  input  logic        final_box,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  batch_out,
  output logic [7:0]  class_out,
  output logic [5:0]  chosen_box,
  output logic        none_chosen,
  output logic        final_result
);
  import gnms_pkg::*;

  logic        coord_format, score_filter_on;
  logic [6:0]  max_per_class;
  logic [15:0] iou_threshold_q, score_threshold_q;
  logic        st_we, job_valid, job_take, busy;
  logic [IdxW-1:0] st_addr;
  set_job_t    job;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coord_format <= 1'b0; max_per_class <= '0; iou_threshold_q <= '0;
      score_filter_on <= 1'b0; score_threshold_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCoordFormat: coord_format      <= cfg_data[0];
        RegMaxPerClass: max_per_class     <= cfg_data[6:0];
        RegIouThresh:   iou_threshold_q   <= cfg_data;
        RegScoreFilter: score_filter_on   <= cfg_data[0];
        RegScoreThresh: score_threshold_q <= cfg_data;
        default: ;
      endcase
    end
  end

  gnms_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_final(final_box),
    .in_batch(batch_tag), .in_class(class_tag), .back_busy(busy),
    .in_stall(in_stall), .store_we(st_we), .store_addr(st_addr),
    .job_valid(job_valid), .job(job), .job_take(job_take));

  gnms_back u_back (
    .clk(clk), .rst(rst), .cfg_fmt(coord_format), .cfg_max(max_per_class),
    .cfg_iou(iou_threshold_q), .cfg_filt(score_filter_on),
    .cfg_sthr(score_threshold_q), .job_valid(job_valid), .job(job),
    .job_take(job_take), .busy(busy), .st_we(st_we), .st_waddr(st_addr),
    .st_box({coord_a, coord_b, coord_c, coord_d}), .st_score(box_score),
    .out_valid(out_valid), .out_stall(out_stall), .batch_out(batch_out),
    .class_out(class_out), .chosen_box(chosen_box), .none_chosen(none_chosen),
    .final_result(final_result));
endmodule

/* rtl/core/gnms_checker.sv */
// Port-level checker for the greedy non-maximum suppression block, and its bind.
// Depends only on the top-level ports.
module gnms_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic none_chosen,
  input logic final_result,
  input logic [5:0] chosen_box
);
  // A set with no accepted box gives one closing result.
  a_none_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_chosen |-> final_result) else $error("none without final");

  // Results are never shown while boxes are being taken.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("output while input open");

  // No box transfer happens in a cycle that offers a result.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !out_valid) else $error("input transfer during output");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chosen_box))
    else $error("stalled result changed");
endmodule

bind greedy_non_max_suppression gnms_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .none_chosen(none_chosen),
  .final_result(final_result), .chosen_box(chosen_box));

/* bench/tb_greedy_non_max_suppression.sv */
// Self-checking testbench for greedy_non_max_suppression: random box sets under several
// register settings, each checked against a behavioral selection model.
// Depends on gnms_pkg and the block's RTL only.
module tb_greedy_non_max_suppression;
  import gnms_pkg::*;

  localparam int CycleLimit = 1500000;

  // Expected results and the selection model that produces them.
  class nms_scoreboard;
    typedef struct {
      bit [7:0] batch;
      bit [7:0] klass;
      bit [5:0] idx;
      bit       none;
      bit       last;
    } pick_t;

    bit        fmt;
    bit [6:0]  max_keep;
    bit [15:0] iou_q;
    bit        filt_on;
    bit [15:0] score_q;
    longint    coords[64][4];
    bit [15:0] scores[64];
    int        n_boxes;
    pick_t     picks[$];
    int        errors;

    function void set_reg(bit [2:0] idx, bit [15:0] val);
      case (idx)
        RegCoordFormat: fmt = val[0];
        RegMaxPerClass: max_keep = val[6:0];
        RegIouThresh:   iou_q = val;
        RegScoreFilter: filt_on = val[0];
        RegScoreThresh: score_q = val;
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Edges in doubled units, so centre boxes need no halving.
    function void edges_of(int i, output longint xl, xh, yl, yh);
      longint a, b, c, d;
      a = coords[i][0]; b = coords[i][1]; c = coords[i][2]; d = coords[i][3];
      if (!fmt) begin
        xl = 2 * ((b < d) ? b : d); xh = 2 * ((b < d) ? d : b);
        yl = 2 * ((a < c) ? a : c); yh = 2 * ((a < c) ? c : a);
      end else begin
        xl = 2 * a - c; xh = 2 * a + c;
        yl = 2 * b - d; yh = 2 * b + d;
      end
    endfunction

    // True when box i overlaps kept box j by more than the IoU threshold.
    function bit suppressed(int i, int j);
      longint pxl, pxh, pyl, pyh, qxl, qxh, qyl, qyh;
      longint ixl, ixh, iyl, iyh, inter, uni;
      edges_of(i, pxl, pxh, pyl, pyh);
      edges_of(j, qxl, qxh, qyl, qyh);
      ixl = (pxl > qxl) ? pxl : qxl;
      ixh = (pxh < qxh) ? pxh : qxh;
      iyl = (pyl > qyl) ? pyl : qyl;
      iyh = (pyh < qyh) ? pyh : qyh;
      if (ixh <= ixl || iyh <= iyl) return 0;
      inter = (ixh - ixl) * (iyh - iyl);
      uni = (pxh - pxl) * (pyh - pyl) + (qxh - qxl) * (qyh - qyl) - inter;
      return inter * 65536 > longint'(iou_q) * uni;
    endfunction

    // Store an accepted box; on the final box run the selection.
    function void note_box(bit [7:0] bt, bit [7:0] ct, bit [15:0] a, b, c, d,
                           bit [15:0] s, bit fin);
      int order[$];
      int kept[$];
      int pos, limit;
      bit ok;
      pick_t p;
      if (n_boxes < 64) begin
        coords[n_boxes][0] = longint'(signed'(a));
        coords[n_boxes][1] = longint'(signed'(b));
        coords[n_boxes][2] = longint'(signed'(c));
        coords[n_boxes][3] = longint'(signed'(d));
        scores[n_boxes] = s;
        n_boxes++;
      end
      if (!fin) return;
      for (int i = 0; i < n_boxes; i++) begin
        if (filt_on && scores[i] <= score_q) continue;
        pos = order.size();
        while (pos > 0 && scores[order[pos-1]] < scores[i]) pos--;
        order.insert(pos, i);
      end
      limit = (max_keep > 64) ? 64 : max_keep;
      foreach (order[n]) begin
        if (kept.size() >= limit) break;
        ok = 1;
        foreach (kept[k]) if (suppressed(order[n], kept[k])) begin
          ok = 0;
          break;
        end
        if (ok) kept = {kept, order[n]};
      end
      n_boxes = 0;
      p.batch = bt; p.klass = ct;
      if (kept.size() == 0) begin
        p.idx = 0; p.none = 1; p.last = 1;
        picks = {picks, p};
      end
      foreach (kept[k]) begin
        p.idx = 6'(kept[k]); p.none = 0; p.last = (k == kept.size() - 1);
        picks = {picks, p};
      end
    endfunction

    task check(bit [7:0] bt, bit [7:0] ct, bit [5:0] idx, bit none, bit last);
      pick_t p;
      if (picks.size() == 0) begin
        report($sformatf("unexpected result idx=%0d", idx));
        return;
      end
      p = picks.pop_front();
      if (bt != p.batch) report($sformatf("batch_out %0d, want %0d", bt, p.batch));
      if (ct != p.klass) report($sformatf("class_out %0d, want %0d", ct, p.klass));
      if (idx != p.idx) report($sformatf("chosen_box %0d, want %0d", idx, p.idx));
      if (none != p.none) report($sformatf("none_chosen %0d, want %0d", none, p.none));
      if (last != p.last) report($sformatf("final_result %0d, want %0d", last, p.last));
    endtask
  endclass

  logic        clk = 0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  batch_tag, class_tag;
  logic signed [15:0] coord_a, coord_b, coord_c, coord_d;
  logic [15:0] box_score;
  logic        final_box;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  batch_out, class_out;
  logic [5:0]  chosen_box;
  logic        none_chosen, final_result;

  nms_scoreboard sb = new();
  int cycles = 0;
  int stall_left = 0;
  int n_sent;
  bit calm;
  logic [7:0] cur_batch, cur_class;

  greedy_non_max_suppression u_dut (.*);

  always #6 clk = ~clk;

  // Cycle count and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stalls: mostly short bursts, a few long ones.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if ($urandom_range(0, 99) < 70) begin
      out_stall <= 0;
    end else begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_stall <= 1;
    end
  end

  // Compare every result transfer.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check(batch_out, class_out, chosen_box, none_chosen, final_result);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Write all five registers; the block must be idle.
  task automatic write_regs(bit fmt, bit [6:0] mx, bit [15:0] iou, bit fon, bit [15:0] sth);
    bit [15:0] vals[5];
    vals = '{16'(fmt), 16'(mx), iou, 16'(fon), sth};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(i[2:0], vals[i]);
    end
    cfg_we <= 0;
  endtask

  // One box transfer, then an optional gap.
  task automatic send_box(bit [15:0] a, b, c, d, bit [15:0] s, bit fin);
    int gap;
    in_valid <= 1;
    batch_tag <= cur_batch; class_tag <= cur_class;
    coord_a <= a; coord_b <= b; coord_c <= c; coord_d <= d;
    box_score <= s; final_box <= fin;
    do @(posedge clk); while (in_stall);
    sb.note_box(cur_batch, cur_class, a, b, c, d, s, fin);
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.picks.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // A random set: mostly clustered boxes with coarse scores so overlaps and ties occur.
  task automatic random_set();
    int n, bxc, byc;
    bit [15:0] a, b, c, d, s;
    n = ($urandom_range(0, 99) < 3) ? $urandom_range(65, 70) : $urandom_range(1, 8);
    cur_batch = 8'($urandom); cur_class = 8'($urandom);
    calm = ($urandom_range(0, 4) == 0);
    bxc = $urandom_range(0, 2000) - 1000;
    byc = $urandom_range(0, 2000) - 1000;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        a = 16'($urandom); b = 16'($urandom); c = 16'($urandom); d = 16'($urandom);
      end else if (sb.fmt) begin
        a = 16'(bxc + $urandom_range(0, 20)); b = 16'(byc + $urandom_range(0, 20));
        c = ($urandom_range(0, 19) == 0) ? 16'(-$urandom_range(0, 30)) :
                                           16'($urandom_range(0, 60));
        d = ($urandom_range(0, 19) == 0) ? 16'(-$urandom_range(0, 30)) :
                                           16'($urandom_range(0, 60));
      end else begin
        a = 16'(byc + $urandom_range(0, 30)); b = 16'(bxc + $urandom_range(0, 30));
        c = 16'(byc + $urandom_range(0, 60)); d = 16'(bxc + $urandom_range(0, 60));
      end
      s = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 8) * 8192) : 16'($urandom);
      send_box(a, b, c, d, s, i == n - 1);
    end
  endtask

  initial begin
    rst <= 1;
    cfg_we <= 0; cfg_index <= RegCoordFormat; cfg_data <= 0;
    in_valid <= 0; batch_tag <= 0; class_tag <= 0;
    coord_a <= 0; coord_b <= 0; coord_c <= 0; coord_d <= 0;
    box_score <= 0; final_box <= 0;
    n_sent = 0; calm = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, ties, edge contact, zero area, filtered-out set.
    write_regs(0, 64, 16'd32768, 1, 16'd100);
    cur_batch = 8'hff; cur_class = 8'h00;
    send_box(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 0);
    send_box(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 0);
    send_box(0, 0, 10, 10, 16'd500, 0);
    send_box(0, 10, 10, 20, 16'd500, 0);
    send_box(5, 5, 5, 20, 16'd400, 0);
    send_box(5, 5, 5, 20, 16'd400, 0);
    send_box(1, 1, 2, 2, 16'd100, 0);
    send_box(1, 1, 2, 2, 16'd0, 1);
    cur_batch = 8'h00; cur_class = 8'hff;
    send_box(3, 3, 9, 9, 16'd100, 0);
    send_box(3, 3, 9, 9, 16'd7, 1);
    drain();
    write_regs(1, 127, 16'd0, 0, 16'hffff);
    cur_batch = 8'h5a; cur_class = 8'ha5;
    send_box(0, 0, 10, 10, 16'd9, 0);
    send_box(0, 0, -4, 10, 16'd9, 0);
    send_box(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'd8, 0);
    send_box(5, 0, 10, 10, 16'd8, 0);
    send_box(10, 0, 10, 10, 16'd7, 1);
    drain();

    // Random sets under a range of register settings.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_regs(0, 64, 16'd32768, 0, 16'd0);
        1: write_regs(1, 3, 16'd19661, 1, 16'd32768);
        2: write_regs(0, 0, 16'd65535, 0, 16'd0);
        3: write_regs(1, 127, 16'd65535, 1, 16'hffff);
        4: write_regs(0, 1, 16'd0, 1, 16'd0);
        5: write_regs(1, 65, 16'd0, 0, 16'd1000);
        default: write_regs(1'($urandom), 7'($urandom_range(0, 127)), 16'($urandom),
                            1'($urandom), 16'($urandom));
      endcase
      n_sent = 0;
      while (n_sent < 62) random_set();
      drain();
    end

    repeat (40) @(posedge clk);
    if (sb.picks.size() != 0) sb.report($sformatf("%0d results never came", sb.picks.size()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
